FILE: rtl/core/sgpt_pkg.sv
// shared types and constants of the staggered grid particle tracer
`default_nettype none

package sgpt_pkg;

    typedef enum logic [2:0] {
        REG_CELL_WIDTH  = 3'd0,
        REG_CELL_HEIGHT = 3'd1,
        REG_INV_WIDTH   = 3'd2,
        REG_INV_HEIGHT  = 3'd3,
        REG_INV_AREA    = 3'd4,
        REG_COLS_USED   = 3'd5,
        REG_ROWS_USED   = 3'd6,
        REG_TIME_STEP   = 3'd7
    } reg_idx_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TRACE = 1'b1;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [33:0] OFF_ONE   = 34'h100000000;
    localparam logic [33:0] OFF_HALF3 = 34'h180000000;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        fluid;
    } cell_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               active;
        logic               last;
        logic               ok;
    } tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/sgpt_grid_mem.sv
// grid memories for u, v and fluid mark, one write and one registered read each
`default_nettype none

module sgpt_grid_mem
    import sgpt_pkg::*;
#(
    parameter int AW = 12
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire cell_t         wdata,
    input  wire logic [AW-1:0] raddr_u,
    input  wire logic [AW-1:0] raddr_v,
    input  wire logic [AW-1:0] raddr_f,
    output logic [31:0]        rdata_u,
    output logic [31:0]        rdata_v,
    output logic               rdata_f
);

    logic [31:0] u_mem [2**AW];
    logic [31:0] v_mem [2**AW];
    logic        f_mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            u_mem[waddr] <= wdata.u;
            v_mem[waddr] <= wdata.v;
            f_mem[waddr] <= wdata.fluid;
        end
        rdata_u <= u_mem[raddr_u];
        rdata_v <= v_mem[raddr_v];
        rdata_f <= f_mem[raddr_f];
    end

endmodule

`default_nettype wire

FILE: rtl/core/staggered_grid_particle_tracer_core.sv
// top level of the staggered grid particle tracer: config, pipeline and grid access
//
// Takes a new item (grid write or particle) once busy drops, while earlier particles are
// still in the pipeline: busy stays high after each accepted start until the spacing
// counter runs out, because a particle reads four corners from each single-read-port grid
// memory. A particle's result appears on the result ports for one cycle, marked by
// result_valid; grid writes give no result. The receiver cannot stall, so results are never held back.
`default_nettype none

module staggered_grid_particle_tracer_core
    import sgpt_pkg::*;
#(
    parameter int GRID_SIZE = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic [5:0]         cell_col,
    input  wire logic [5:0]         cell_row,
    input  wire logic signed [31:0] cell_u,
    input  wire logic signed [31:0] cell_v,
    input  wire logic               cell_fluid,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic               active,
    input  wire logic               last_particle,
    output logic                    result_valid,
    output logic                    on_screen,
    output logic signed [31:0]      vel_u,
    output logic signed [31:0]      vel_v,
    output logic signed [31:0]      new_x,
    output logic signed [31:0]      new_y,
    output logic                    sweep_end,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = $clog2(GRID_SIZE);
    localparam int AW = 2 * IW;
    localparam int CW = IW + 32;
    localparam int SW = CW + 2;

    // configuration
    logic [30:0] cell_w_reg, cell_h_reg, dt_reg;
    logic [31:0] inv_w_reg, inv_h_reg, inv_a_reg;
    logic [5:0]  cols_reg, rows_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_w_reg <= 31'h10000;
            cell_h_reg <= 31'h10000;
            inv_w_reg  <= 32'h10000;
            inv_h_reg  <= 32'h10000;
            inv_a_reg  <= 32'h10000;
            cols_reg   <= 6'd63;
            rows_reg   <= 6'd63;
            dt_reg     <= 31'h10000;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_CELL_WIDTH:  cell_w_reg <= pwdata[30:0];
                REG_CELL_HEIGHT: cell_h_reg <= pwdata[30:0];
                REG_INV_WIDTH:   inv_w_reg  <= pwdata;
                REG_INV_HEIGHT:  inv_h_reg  <= pwdata;
                REG_INV_AREA:    inv_a_reg  <= pwdata;
                REG_COLS_USED:   cols_reg   <= pwdata[5:0];
                REG_ROWS_USED:   rows_reg   <= pwdata[5:0];
                REG_TIME_STEP:   dt_reg     <= pwdata[30:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_CELL_WIDTH:  prdata = {1'b0, cell_w_reg};
            REG_CELL_HEIGHT: prdata = {1'b0, cell_h_reg};
            REG_INV_WIDTH:   prdata = inv_w_reg;
            REG_INV_HEIGHT:  prdata = inv_h_reg;
            REG_INV_AREA:    prdata = inv_a_reg;
            REG_COLS_USED:   prdata = {26'd0, cols_reg};
            REG_ROWS_USED:   prdata = {26'd0, rows_reg};
            REG_TIME_STEP:   prdata = {1'b0, dt_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // issue spacing and valid chain
    logic [1:0]  gap_reg;
    logic        accept;
    logic [12:0] pv_reg;
    logic [1:0]  wv_reg;

    assign busy   = (gap_reg != 2'd0);
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= 2'd0;
            pv_reg  <= '0;
            wv_reg  <= '0;
        end
        else
        begin
            if (accept)
                gap_reg <= 2'd3;
            else if (busy)
                gap_reg <= gap_reg - 2'd1;
            pv_reg <= {pv_reg[11:0], accept & (func == FUNC_TRACE)};
            wv_reg <= {wv_reg[0], accept & (func == FUNC_WRITE)};
        end
    end

    // stage 0 and 1: capture, position times reciprocal
    tag_t                tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    tag_t                tag6_reg, tag7_reg, tag8_reg, tag9_reg, tag10_reg, tag11_reg;
    logic [5:0]          col0_reg, row0_reg, col1_reg, row1_reg;
    cell_t               cell0_reg, cell1_reg;
    logic signed [63:0]  px1_reg, py1_reg;
    logic signed [63:0]  px1_next, py1_next;

    assign px1_next = 64'(tag0_reg.x) * 64'($signed({1'b0, inv_w_reg}));
    assign py1_next = 64'(tag0_reg.y) * 64'($signed({1'b0, inv_h_reg}));

    // stage 2: cell indices
    function automatic logic [IW:0] cell_idx(input logic signed [63:0] p,
                                             input logic [33:0] off,
                                             input logic [5:0] lim);
        logic signed [65:0] s;
        logic [32:0]        k;
        logic               ok;
        s  = 66'(p) + $signed({32'd0, off});
        k  = s[64:32];
        ok = !s[65] && (k != 33'd0) && (k < 33'(lim)) && (k < 33'(GRID_SIZE));
        return {ok, k[IW-1:0]};
    endfunction

    logic [IW:0]   iu_c, ju_c, iv_c, jv_c;
    logic [IW-1:0] iu2_reg, ju2_reg, iv2_reg, jv2_reg;

    assign iu_c = cell_idx(px1_reg, OFF_ONE,   cols_reg);
    assign ju_c = cell_idx(py1_reg, OFF_HALF3, rows_reg);
    assign iv_c = cell_idx(px1_reg, OFF_HALF3, cols_reg);
    assign jv_c = cell_idx(py1_reg, OFF_ONE,   rows_reg);

    // grid reads, four corners per particle
    logic          rd_on_reg, rdv_reg;
    logic [1:0]    rd_ph_reg, rdc_reg;
    logic [1:0]    cur_ph;
    logic          rd_go;
    logic [IW-1:0] iu_m, ju_m, iv_m, jv_m;
    logic [AW-1:0] raddr_u, raddr_v, raddr_f, waddr;
    logic          we;
    logic [31:0]   rdata_u, rdata_v;
    logic          rdata_f;
    logic [31:0]   fu_reg [4];
    logic [31:0]   fv_reg [4];
    logic          flu_reg, flv_reg;

    assign cur_ph = pv_reg[2] ? 2'd0 : rd_ph_reg;
    assign rd_go  = pv_reg[2] | rd_on_reg;
    assign iu_m   = iu2_reg - IW'(1);
    assign ju_m   = ju2_reg - IW'(1);
    assign iv_m   = iv2_reg - IW'(1);
    assign jv_m   = jv2_reg - IW'(1);

    assign raddr_u = {cur_ph[0] ? iu2_reg : iu_m, cur_ph[1] ? ju2_reg : ju_m};
    assign raddr_v = {cur_ph[0] ? iv2_reg : iv_m, cur_ph[1] ? jv2_reg : jv_m};
    assign raddr_f = cur_ph[0] ? {iv2_reg, jv2_reg} : {iu2_reg, ju2_reg};

    assign we    = wv_reg[1] && (32'(col1_reg) < GRID_SIZE) && (32'(row1_reg) < GRID_SIZE);
    assign waddr = {IW'(col1_reg), IW'(row1_reg)};

    sgpt_grid_mem #(
        .AW (AW)
    ) u_grid (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (cell1_reg),
        .raddr_u (raddr_u),
        .raddr_v (raddr_v),
        .raddr_f (raddr_f),
        .rdata_u (rdata_u),
        .rdata_v (rdata_v),
        .rdata_f (rdata_f)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_on_reg <= 1'b0;
            rd_ph_reg <= 2'd0;
            rdv_reg   <= 1'b0;
            rdc_reg   <= 2'd0;
        end
        else
        begin
            rdv_reg <= rd_go;
            rdc_reg <= cur_ph;
            if (pv_reg[2])
            begin
                rd_on_reg <= 1'b1;
                rd_ph_reg <= 2'd1;
            end
            else if (rd_on_reg)
            begin
                rd_ph_reg <= rd_ph_reg + 2'd1;
                if (rd_ph_reg == 2'd3)
                    rd_on_reg <= 1'b0;
            end
        end
    end

    // weight datapath
    function automatic logic [30:0] clamp_w(input logic signed [SW-1:0] v,
                                            input logic [30:0] hi);
        if (v < 0)
            return 31'd0;
        else if (v > $signed({{(SW-31){1'b0}}, hi}))
            return hi;
        return v[30:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    logic [CW-1:0]         x2u3_reg, y2u3_reg, x2v3_reg, y2v3_reg;
    logic [30:0]           xw4_reg [2][2];
    logic [30:0]           yw4_reg [2][2];
    logic [30:0]           xw4_next [2][2];
    logic [30:0]           yw4_next [2][2];
    logic                  big5_reg [2][4];
    logic [32:0]           lo5_reg [2][4];
    logic                  big5_next [2][4];
    logic [32:0]           lo5_next [2][4];
    logic [61:0]           wxy [2][4];
    logic [64:0]           m6_reg [2][4];
    logic                  big6_reg [2][4];
    logic [16:0]           w7_reg [2][4];
    logic signed [49:0]    pr8_reg [2][4];
    logic signed [51:0]    sum9_reg [2];
    logic signed [31:0]    vel10_reg [2];
    logic signed [63:0]    pr11_reg [2];
    logic signed [SW-1:0]  xs3, ys3, dxs, dys;
    logic signed [SW-1:0]  x2s [2];
    logic signed [SW-1:0]  y2s [2];

    assign xs3    = SW'(tag3_reg.x);
    assign ys3    = SW'(tag3_reg.y);
    assign dxs    = $signed({{(SW-31){1'b0}}, cell_w_reg});
    assign dys    = $signed({{(SW-31){1'b0}}, cell_h_reg});
    assign x2s[0] = $signed({2'b00, x2u3_reg});
    assign y2s[0] = $signed({2'b00, y2u3_reg});
    assign x2s[1] = $signed({2'b00, x2v3_reg});
    assign y2s[1] = $signed({2'b00, y2v3_reg});

    always_comb
    begin
        for (int f = 0; f < 2; f++)
        begin
            xw4_next[f][0] = clamp_w(x2s[f] - xs3, cell_w_reg);
            xw4_next[f][1] = clamp_w(xs3 - x2s[f] + dxs, cell_w_reg);
            yw4_next[f][0] = clamp_w(y2s[f] - ys3, cell_h_reg);
            yw4_next[f][1] = clamp_w(ys3 - y2s[f] + dys, cell_h_reg);
        end
    end

    always_comb
    begin
        for (int f = 0; f < 2; f++)
        begin
            for (int cy = 0; cy < 2; cy++)
            begin
                for (int cx = 0; cx < 2; cx++)
                begin
                    wxy[f][cy*2+cx]       = 62'(xw4_reg[f][cx]) * 62'(yw4_reg[f][cy]);
                    big5_next[f][cy*2+cx] = |wxy[f][cy*2+cx][61:49];
                    lo5_next[f][cy*2+cx]  = wxy[f][cy*2+cx][48:16];
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag0_reg  <= '{x: pos_x, y: pos_y, active: active, last: last_particle, ok: 1'b0};
            col0_reg  <= cell_col;
            row0_reg  <= cell_row;
            cell0_reg <= '{u: cell_u, v: cell_v, fluid: cell_fluid};
        end
        if (pv_reg[0] | wv_reg[0])
        begin
            tag1_reg  <= tag0_reg;
            col1_reg  <= col0_reg;
            row1_reg  <= row0_reg;
            cell1_reg <= cell0_reg;
            px1_reg   <= px1_next;
            py1_reg   <= py1_next;
        end
        if (pv_reg[1])
        begin
            tag2_reg <= '{x: tag1_reg.x, y: tag1_reg.y, active: tag1_reg.active,
                          last: tag1_reg.last,
                          ok: iu_c[IW] & ju_c[IW] & iv_c[IW] & jv_c[IW]};
            iu2_reg  <= iu_c[IW-1:0];
            ju2_reg  <= ju_c[IW-1:0];
            iv2_reg  <= iv_c[IW-1:0];
            jv2_reg  <= jv_c[IW-1:0];
        end
        if (rdv_reg)
        begin
            fu_reg[rdc_reg] <= rdata_u;
            fv_reg[rdc_reg] <= rdata_v;
            if (rdc_reg == 2'd0)
                flu_reg <= rdata_f;
            if (rdc_reg == 2'd1)
                flv_reg <= rdata_f;
        end
        if (pv_reg[2])
        begin
            tag3_reg <= tag2_reg;
            x2u3_reg <= CW'(iu2_reg) * CW'(cell_w_reg);
            y2u3_reg <= CW'((CW'({ju_m, 1'b1}) * CW'(cell_h_reg)) >> 1);
            x2v3_reg <= CW'((CW'({iv_m, 1'b1}) * CW'(cell_w_reg)) >> 1);
            y2v3_reg <= CW'(jv2_reg) * CW'(cell_h_reg);
        end
        if (pv_reg[3])
        begin
            tag4_reg <= tag3_reg;
            xw4_reg  <= xw4_next;
            yw4_reg  <= yw4_next;
        end
        if (pv_reg[4])
        begin
            tag5_reg <= tag4_reg;
            big5_reg <= big5_next;
            lo5_reg  <= lo5_next;
        end
        if (pv_reg[5])
        begin
            tag6_reg <= tag5_reg;
            for (int f = 0; f < 2; f++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    m6_reg[f][c]   <= 65'(lo5_reg[f][c]) * 65'(inv_a_reg);
                    big6_reg[f][c] <= big5_reg[f][c] & (inv_a_reg != 32'd0);
                end
            end
        end
        if (pv_reg[6])
        begin
            tag7_reg <= tag6_reg;
            for (int f = 0; f < 2; f++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    if (big6_reg[f][c] || (m6_reg[f][c][64:16] > 49'(ONE_Q16)))
                        w7_reg[f][c] <= ONE_Q16;
                    else
                        w7_reg[f][c] <= m6_reg[f][c][32:16];
                end
            end
        end
        if (pv_reg[7])
        begin
            tag8_reg <= '{x: tag7_reg.x, y: tag7_reg.y, active: tag7_reg.active,
                          last: tag7_reg.last,
                          ok: tag7_reg.active & tag7_reg.ok & flu_reg & flv_reg};
            for (int c = 0; c < 4; c++)
            begin
                pr8_reg[0][c] <= $signed({1'b0, w7_reg[0][c]}) * $signed(fu_reg[c]);
                pr8_reg[1][c] <= $signed({1'b0, w7_reg[1][c]}) * $signed(fv_reg[c]);
            end
        end
        if (pv_reg[8])
        begin
            tag9_reg <= tag8_reg;
            for (int f = 0; f < 2; f++)
                sum9_reg[f] <= 52'(pr8_reg[f][0]) + 52'(pr8_reg[f][1])
                             + 52'(pr8_reg[f][2]) + 52'(pr8_reg[f][3]);
        end
        if (pv_reg[9])
        begin
            tag10_reg <= tag9_reg;
            for (int f = 0; f < 2; f++)
                vel10_reg[f] <= tag9_reg.ok ? sat32(64'(sum9_reg[f] >>> 16)) : 32'sd0;
        end
        if (pv_reg[10])
        begin
            tag11_reg <= tag10_reg;
            for (int f = 0; f < 2; f++)
                pr11_reg[f] <= 64'(vel10_reg[f]) * 64'($signed({1'b0, dt_reg}));
        end
        if (pv_reg[11])
        begin
            on_screen <= tag11_reg.ok;
            vel_u     <= vel10_reg[0];
            vel_v     <= vel10_reg[1];
            new_x     <= sat32(64'(tag11_reg.x) + (pr11_reg[0] >>> 16));
            new_y     <= sat32(64'(tag11_reg.y) + (pr11_reg[1] >>> 16));
            sweep_end <= tag11_reg.last;
        end
    end

    assign result_valid = pv_reg[12];

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted beat");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !on_screen) |-> (vel_u == 32'sd0 && vel_v == 32'sd0))
        else $error("dropped particle with nonzero velocity");

    a_read_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg[2] |-> !rd_on_reg)
        else $error("corner reads of two particles overlap");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the staggered grid particle tracer core: random grid loads and particle traces
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import sgpt_pkg::*;

    localparam int GRID = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [33:0] OFS_ONE = 34'h100000000;
    localparam logic [33:0] OFS_HALF3 = 34'h180000000;

    typedef struct {
        logic        func;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] u;
        logic [31:0] v;
        logic        fluid;
        logic [31:0] x;
        logic [31:0] y;
        logic        act;
        logic        last;
    } item_t;

    typedef struct {
        logic        alive;
        logic [31:0] vu;
        logic [31:0] vv;
        logic [31:0] nx;
        logic [31:0] ny;
        logic        se;
    } trace_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic func = 1'b0;
    logic [5:0] cell_col = '0;
    logic [5:0] cell_row = '0;
    logic signed [31:0] cell_u = '0;
    logic signed [31:0] cell_v = '0;
    logic cell_fluid = 1'b0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic active = 1'b0;
    logic last_particle = 1'b0;
    logic result_valid;
    logic on_screen;
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic sweep_end;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    staggered_grid_particle_tracer_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of grid and registers
    logic [31:0] grid_u [GRID*GRID];
    logic [31:0] grid_v [GRID*GRID];
    logic        grid_f [GRID*GRID];
    logic [31:0] r_dx, r_dy, r_idx, r_idy, r_iarea, r_cols, r_rows, r_dt;

    item_t  pending_items [$];
    trace_t expected_traces [$];
    int     errors = 0;
    int     gap = 0;
    bit     hold_off = 1'b0;
    bit     cfg_busy = 1'b0;
    int     idle_cycles = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clampw(longint v, longint hi);
        if (v < 0) return 0;
        return (v > hi) ? hi : v;
    endfunction

    function automatic bit find_cell(longint p, logic [31:0] inv, logic [33:0] ofs,
                                     logic [31:0] lim, output int idx);
        longint prod;
        logic [63:0] k;
        prod = p * longint'({32'd0, inv});
        idx = 0;
        if (prod < longint'(OFS_ONE) - longint'(ofs)) return 1'b0;
        k = (64'(prod) + 64'(ofs)) >> 32;
        if (k >= 64'(lim) || k >= GRID) return 1'b0;
        idx = int'(k);
        return 1'b1;
    endfunction

    function automatic longint weight(longint wx, longint wy);
        logic [63:0] a, w;
        a = (64'(wx) * 64'(wy)) >> 16;
        if (r_iarea == 0) return 0;
        if (a > (64'd1 << 33) / 64'(r_iarea)) return 65536;
        w = (a * 64'(r_iarea)) >> 16;
        return (w > 64'd65536) ? 65536 : longint'(w);
    endfunction

    function automatic longint bilerp(bit use_u, int i, int j, longint x, longint y,
                                      longint x2, longint y2);
        longint ddx, ddy, ax, bx, ay, by, s;
        int lo, hi;
        ddx = longint'({32'd0, r_dx});
        ddy = longint'({32'd0, r_dy});
        ax = clampw(x2 - x, ddx);
        bx = clampw(x - x2 + ddx, ddx);
        ay = clampw(y2 - y, ddy);
        by = clampw(y - y2 + ddy, ddy);
        lo = (i - 1) * GRID;
        hi = i * GRID;
        if (use_u)
            s = weight(ax, ay) * longint'($signed(grid_u[lo+j-1]))
              + weight(bx, ay) * longint'($signed(grid_u[hi+j-1]))
              + weight(ax, by) * longint'($signed(grid_u[lo+j]))
              + weight(bx, by) * longint'($signed(grid_u[hi+j]));
        else
            s = weight(ax, ay) * longint'($signed(grid_v[lo+j-1]))
              + weight(bx, ay) * longint'($signed(grid_v[hi+j-1]))
              + weight(ax, by) * longint'($signed(grid_v[lo+j]))
              + weight(bx, by) * longint'($signed(grid_v[hi+j]));
        return sat32(s >>> 16);
    endfunction

    // apply one accepted item to the shadow grid, or return the traced particle
    function automatic bit trace_particle(item_t it, output trace_t r);
        longint x, y, vu, vv, nx, ny;
        int i, j;
        bit ok;
        int a;
        r = '{default: '0};
        if (it.func == FUNC_WRITE) begin
            a = int'(it.col) * GRID + int'(it.row);
            grid_u[a] = it.u;
            grid_v[a] = it.v;
            grid_f[a] = it.fluid;
            return 1'b0;
        end
        x = longint'($signed(it.x));
        y = longint'($signed(it.y));
        nx = x; ny = y; vu = 0; vv = 0;
        ok = it.act;
        if (ok) begin
            ok = find_cell(x, r_idx, OFS_ONE, r_cols, i)
              && find_cell(y, r_idy, OFS_HALF3, r_rows, j);
            if (ok) ok = grid_f[i*GRID+j];
            if (ok)
                vu = bilerp(1'b1, i, j, x, y, longint'(i) * longint'({32'd0, r_dx}),
                            longint'((64'(2*j-1) * 64'(r_dy)) >> 1));
        end
        if (ok) begin
            ok = find_cell(x, r_idx, OFS_HALF3, r_cols, i)
              && find_cell(y, r_idy, OFS_ONE, r_rows, j);
            if (ok) ok = grid_f[i*GRID+j];
            if (ok)
                vv = bilerp(1'b0, i, j, x, y, longint'((64'(2*i-1) * 64'(r_dx)) >> 1),
                            longint'(j) * longint'({32'd0, r_dy}));
        end
        if (ok) begin
            nx = sat32(x + ((vu * longint'({32'd0, r_dt})) >>> 16));
            ny = sat32(y + ((vv * longint'({32'd0, r_dt})) >>> 16));
        end else begin
            vu = 0; vv = 0;
        end
        r.alive = ok;
        r.vu = vu[31:0];
        r.vv = vv[31:0];
        r.nx = nx[31:0];
        r.ny = ny[31:0];
        r.se = it.last;
        return 1'b1;
    endfunction

    // driver
    always @(posedge clk)
    begin
        item_t it;
        trace_t r;
        if (start && !busy) begin
            it.func = func; it.col = cell_col; it.row = cell_row;
            it.u = cell_u; it.v = cell_v; it.fluid = cell_fluid;
            it.x = pos_x; it.y = pos_y; it.act = active; it.last = last_particle;
            if (trace_particle(it, r)) expected_traces.push_back(r);
        end
        if (start && busy) begin
        end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
        end else if (rst_n && !hold_off && !cfg_busy && pending_items.size() > 0) begin
            it = pending_items.pop_front();
            func <= it.func; cell_col <= it.col; cell_row <= it.row;
            cell_u <= it.u; cell_v <= it.v; cell_fluid <= it.fluid;
            pos_x <= it.x; pos_y <= it.y; active <= it.act; last_particle <= it.last;
            start <= 1'b1;
            gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        trace_t e;
        if (result_valid) begin
            if (expected_traces.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = expected_traces.pop_front();
                if (on_screen !== e.alive) begin
                    $error("on_screen exp %0h got %0h", e.alive, on_screen); errors++;
                end
                if (vel_u !== e.vu) begin
                    $error("vel_u exp %0h got %0h", e.vu, vel_u); errors++;
                end
                if (vel_v !== e.vv) begin
                    $error("vel_v exp %0h got %0h", e.vv, vel_v); errors++;
                end
                if (new_x !== e.nx) begin
                    $error("new_x exp %0h got %0h", e.nx, new_x); errors++;
                end
                if (new_y !== e.ny) begin
                    $error("new_y exp %0h got %0h", e.ny, new_y); errors++;
                end
                if (sweep_end !== e.se) begin
                    $error("sweep_end exp %0h got %0h", e.se, sweep_end); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (result_valid || (start && !busy) || cfg_busy) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(int'(idx) * 4); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CELL_WIDTH:  r_dx = val & 32'h7FFFFFFF;
            REG_CELL_HEIGHT: r_dy = val & 32'h7FFFFFFF;
            REG_INV_WIDTH:   r_idx = val;
            REG_INV_HEIGHT:  r_idy = val;
            REG_INV_AREA:    r_iarea = val;
            REG_COLS_USED:   r_cols = val & 32'h3F;
            REG_ROWS_USED:   r_rows = val & 32'h3F;
            default:         r_dt = val & 32'h7FFFFFFF;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || start || expected_traces.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // dx, dy as Q16.16 with matching width and height reciprocals
    task automatic set_grid(logic [31:0] dx, logic [31:0] dy, logic [31:0] dt,
                            logic [31:0] cols, logic [31:0] rows);
        cfg_busy = 1'b1;
        reg_write(REG_CELL_WIDTH, dx);
        reg_write(REG_CELL_HEIGHT, dy);
        reg_write(REG_INV_WIDTH, 32'((64'd1 << 32) / 64'(dx)));
        reg_write(REG_INV_HEIGHT, 32'((64'd1 << 32) / 64'(dy)));
        reg_write(REG_INV_AREA, 32'((64'd1 << 48) / (64'(dx) * 64'(dy) >> 16 | 64'd1)));
        reg_write(REG_COLS_USED, cols);
        reg_write(REG_ROWS_USED, rows);
        reg_write(REG_TIME_STEP, dt);
        cfg_busy = 1'b0;
    endtask

    function automatic item_t cell_write(int c, int r, logic [31:0] u, logic [31:0] v,
                                         logic f);
        item_t it;
        it = '{default: '0};
        it.func = FUNC_WRITE;
        it.col = 6'(c); it.row = 6'(r); it.u = u; it.v = v; it.fluid = f;
        it.x = $urandom; it.y = $urandom;
        it.act = 1'($urandom); it.last = 1'($urandom);
        return it;
    endfunction

    function automatic item_t particle(logic [31:0] x, logic [31:0] y, logic act,
                                       logic last);
        item_t it;
        it = '{default: '0};
        it.func = FUNC_TRACE;
        it.x = x; it.y = y; it.act = act; it.last = last;
        it.col = 6'($urandom); it.row = 6'($urandom); it.u = $urandom; it.v = $urandom;
        it.fluid = 1'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    // a position inside the written interior, in grid units scaled by spacing, or sometimes a random word
    function automatic logic [31:0] rand_pos(logic [31:0] d, int lim);
        logic [63:0] p;
        if ($urandom_range(0, 9) == 0) return $urandom;
        p = (64'(d) * 64'($urandom_range(0, (lim - 1) * 65536))) >> 16;
        return p[31:0];
    endfunction

    task automatic fill_grid(int span);
        for (int c = 0; c < span; c++)
            for (int r = 0; r < span; r++)
                pending_items.push_back(cell_write(c, r, rand_vel(), rand_vel(),
                                                   $urandom_range(0, 7) != 0));
    endtask

    // particles only where every read entry has been written
    task automatic random_particles(int n, int span, logic [31:0] dx, logic [31:0] dy);
        item_t it;
        int i, j;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                it = cell_write($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                                rand_vel(), rand_vel(), $urandom_range(0, 3) != 0);
                pending_items.push_back(it);
            end
            it = particle(rand_pos(dx, span), rand_pos(dy, span),
                          $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        for (int a = 0; a < GRID*GRID; a++) begin
            grid_u[a] = '0; grid_v[a] = '0; grid_f[a] = 1'b0;
        end
        r_dx = 65536; r_dy = 65536; r_idx = 65536; r_idy = 65536; r_iarea = 65536;
        r_cols = 63; r_rows = 63; r_dt = 65536;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: small used region so no unwritten entry can be read
        set_grid(32'h10000, 32'h10000, 32'h10000, 5, 5);
        fill_grid(6);
        pending_items.push_back(particle(32'h00018000, 32'h00018000, 1'b1, 1'b0));
        pending_items.push_back(particle(32'h00018000, 32'h00018000, 1'b0, 1'b1));
        pending_items.push_back(particle(32'h80000000, 32'h00018000, 1'b1, 1'b0));
        pending_items.push_back(particle(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1));
        pending_items.push_back(particle(32'h00000000, 32'h00000000, 1'b1, 1'b0));
        pending_items.push_back(particle(32'h00040000, 32'h00020000, 1'b1, 1'b0));
        pending_items.push_back(particle(32'hFFFFFFFF, 32'h00020000, 1'b1, 1'b0));
        pending_items.push_back(cell_write(2, 2, 32'h7FFFFFFF, 32'h80000000, 1'b0));
        pending_items.push_back(particle(32'h00020000, 32'h00020000, 1'b1, 1'b0));
        pending_items.push_back(cell_write(63, 63, 32'h1, 32'hFFFFFFFF, 1'b1));
        pending_items.push_back(cell_write(2, 2, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
        pending_items.push_back(particle(32'h00028000, 32'h00020000, 1'b1, 1'b1));
        wait_idle();

        // limits below two drop everything
        set_grid(32'h10000, 32'h10000, 32'h7FFFFFFF, 1, 0);
        random_particles(20, 6, 32'h10000, 32'h10000);
        wait_idle();

        // zero inverse area, extreme step
        set_grid(32'h10000, 32'h10000, 32'h7FFFFFFF, 5, 5);
        cfg_busy = 1'b1;
        reg_write(REG_INV_AREA, 32'h0);
        cfg_busy = 1'b0;
        random_particles(30, 6, 32'h10000, 32'h10000);
        wait_idle();

        // inconsistent reciprocals, extremes
        cfg_busy = 1'b1;
        reg_write(REG_INV_AREA, 32'hFFFFFFFF);
        reg_write(REG_INV_WIDTH, 32'hFFFFFFFF);
        reg_write(REG_CELL_WIDTH, 32'h7FFFFFFF);
        reg_write(REG_CELL_HEIGHT, 32'h1);
        reg_write(REG_TIME_STEP, 32'h0);
        cfg_busy = 1'b0;
        random_particles(40, 6, 32'h8000, 32'h10000);
        wait_idle();

        // larger grid with fine spacing
        set_grid(32'h4000, 32'h6000, 32'h8000, 20, 20);
        fill_grid(21);
        random_particles(150, 21, 32'h4000, 32'h6000);
        // wait until everything is back, then hold the sender off before the next batch
        wait_idle();
        hold_off = 1'b1;
        repeat (20) @(posedge clk);
        hold_off = 1'b0;
        random_particles(150, 21, 32'h4000, 32'h6000);
        wait_idle();

        set_grid(32'h30000, 32'h18000, 32'h10000, 20, 20);
        random_particles(270, 21, 32'h30000, 32'h18000);
        wait_idle();

        set_grid(32'h10000, 32'h10000, 32'h7FFFFFFF, 20, 20);
        random_particles(200, 21, 32'h10000, 32'h10000);
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/sgpt_pkg.sv
rtl/core/sgpt_grid_mem.sv
rtl/core/staggered_grid_particle_tracer_core.sv
tb/sv/tb.sv
